// ----- src/aes_pkg.sv -----
package aes_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KeyWords = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] LowSevenMask = 32'h7f7f7f7f;
  localparam logic [WordW-1:0] HighBitMask = 32'h80808080;
  localparam logic [7:0] Reduce = 8'h1b;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       decrypt;
    logic       last;
    logic       first;
  } lane_ctl_t;

  function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[a];
  endfunction

  function automatic logic [WordW-1:0] sub_word(input logic [WordW-1:0] w);
    return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
  endfunction

endpackage

// ----- src/aes_ram.sv -----
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/aes_lane.sv -----
module aes_lane (
  input  logic                     clk_i,
  input  aes_pkg::lane_ctl_t       ctl_i,
  input  logic                     en_i,
  input  logic [aes_pkg::WordW-1:0] load_i,
  input  logic [aes_pkg::WordW-1:0] b0_i,
  input  logic [aes_pkg::WordW-1:0] b1_i,
  input  logic [aes_pkg::WordW-1:0] b2_i,
  input  logic [aes_pkg::WordW-1:0] b3_i,
  input  logic [aes_pkg::WordW-1:0] rk_i,
  output logic [aes_pkg::WordW-1:0] col_o
);

  logic [aes_pkg::WordW-1:0] col_q, col_d, sb, x2, x4, x8, x9, mix, unmix, keyed;

  function automatic logic [aes_pkg::WordW-1:0] dbl4(input logic [aes_pkg::WordW-1:0] x);
    logic [aes_pkg::WordW-1:0] hi;
    hi = (x & aes_pkg::HighBitMask) >> 7;
    return ((x & aes_pkg::LowSevenMask) << 1) ^ (hi * {24'd0, aes_pkg::Reduce});
  endfunction

  // bytes picked by shift rows arrive on b0..b3
  always_comb begin
    if (ctl_i.decrypt) begin
      sb = {aes_pkg::inv_sbox(b0_i[31:24]), aes_pkg::inv_sbox(b1_i[23:16]),
            aes_pkg::inv_sbox(b2_i[15:8]), aes_pkg::inv_sbox(b3_i[7:0])};
    end else begin
      sb = {aes_pkg::fwd_sbox(b0_i[31:24]), aes_pkg::fwd_sbox(b1_i[23:16]),
            aes_pkg::fwd_sbox(b2_i[15:8]), aes_pkg::fwd_sbox(b3_i[7:0])};
    end
    x2 = dbl4(sb);
    mix = x2 ^ {sb[23:0] ^ x2[23:0], sb[31:24] ^ x2[31:24]} ^ {sb[15:0], sb[31:16]}
          ^ {sb[7:0], sb[31:8]};
    keyed = sb ^ rk_i;
    x2 = dbl4(keyed);
    x4 = dbl4(x2);
    x8 = dbl4(x4);
    x9 = keyed ^ x8;
    unmix = (x2 ^ x4 ^ x8) ^ {x9[23:0] ^ x2[23:0], x9[31:24] ^ x2[31:24]}
            ^ {x9[15:0] ^ x4[15:0], x9[31:16] ^ x4[31:16]} ^ {x9[7:0], x9[31:8]};
    if (ctl_i.first) begin
      col_d = load_i ^ rk_i;
    end else if (ctl_i.decrypt) begin
      col_d = ctl_i.last ? keyed : unmix;
    end else begin
      col_d = (ctl_i.last ? sb : mix) ^ rk_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

// ----- src/aes128_block_cipher.sv -----
// AES-128 ECB cipher. Raise start with a block and cmd_i (0 encrypt, 1 decrypt)
// while busy is low; result_valid_o marks the output block for one cycle and
// cannot be stalled. After reset or any key write the first block first runs the
// key expansion, one round-key word a cycle into four 11-word RAM banks, then
// ST_DONE reads the first round key. The result follows the ST_FETCH state for the
// initial key addition and one ST_ROUND state per round across four column lanes,
// with the four banks read one round ahead. The next block can be accepted in the
// cycle that presents the result.
module aes128_block_cipher #(
  parameter int unsigned ROUND_COUNT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [31:0] data_word0_i,
  input  logic [31:0] data_word1_i,
  input  logic [31:0] data_word2_i,
  input  logic [31:0] data_word3_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [31:0] result_word0_o,
  output logic [31:0] result_word1_o,
  output logic [31:0] result_word2_o,
  output logic [31:0] result_word3_o
);

  localparam int unsigned Rounds1 = ROUND_COUNT + 1;
  localparam int unsigned RkW = $clog2(Rounds1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXPAND, ST_FETCH, ST_ROUND, ST_DONE
  } state_e;

  state_e state_q;
  logic stale_q, cmd_q;
  logic [31:0] key_q [4];
  logic [31:0] din_q [4];
  logic [RkW-1:0] rnd_q;
  logic [RkW+1:0] wcnt_q;
  logic [31:0] win_q [4];
  logic [7:0] rcon_q;
  logic [31:0] col [4];
  logic [31:0] rk [4];
  logic exp_we;
  logic [31:0] exp_w, exp_t;
  logic [RkW-1:0] rd_addr;
  logic lane_en;
  aes_pkg::lane_ctl_t ctl;

  assign busy = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;

  // expansion: window holds the last four words
  always_comb begin
    exp_t = win_q[3];
    if (wcnt_q[1:0] == 2'd0) begin
      exp_t = aes_pkg::sub_word({exp_t[23:0], exp_t[31:24]}) ^ {rcon_q, 24'd0};
    end
    exp_w = (wcnt_q < (RkW+2)'(4)) ? key_q[wcnt_q[1:0]] : (win_q[0] ^ exp_t);
    exp_we = (state_q == ST_EXPAND);
  end

  // round keys are read one round ahead
  always_comb begin
    rd_addr = rnd_q;
    if (state_q == ST_IDLE) begin
      rd_addr = cmd_i ? RkW'(ROUND_COUNT) : '0;
    end else if (state_q == ST_ROUND && !ctl.last) begin
      rd_addr = cmd_q ? rnd_q - 1'b1 : rnd_q + 1'b1;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    aes_ram #(.Width(32), .Depth(Rounds1)) u_ram (
      .clk_i   (clk_i),
      .we_i    (exp_we && (wcnt_q[1:0] == 2'(b))),
      .waddr_i (wcnt_q[RkW+1:2]),
      .wdata_i (exp_w),
      .raddr_i (rd_addr),
      .rdata_o (rk[b])
    );
  end

  assign ctl.decrypt = cmd_q;
  assign ctl.first = (state_q == ST_FETCH);
  assign ctl.last = cmd_q ? (rnd_q == RkW'(0)) : (rnd_q == RkW'(ROUND_COUNT));
  assign lane_en = (state_q == ST_FETCH) || (state_q == ST_ROUND);

  for (genvar c = 0; c < 4; c++) begin : g_lane
    aes_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .en_i   (lane_en),
      .load_i (din_q[c]),
      .b0_i   (col[c]),
      .b1_i   (cmd_q ? col[(c+3)%4] : col[(c+1)%4]),
      .b2_i   (col[(c+2)%4]),
      .b3_i   (cmd_q ? col[(c+1)%4] : col[(c+3)%4]),
      .rk_i   (rk[c]),
      .col_o  (col[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stale_q <= 1'b1;
      cmd_q <= 1'b0;
      rnd_q <= '0;
      wcnt_q <= '0;
      rcon_q <= 8'h01;
      result_valid_o <= 1'b0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else begin
      result_valid_o <= (state_q == ST_ROUND) && ctl.last;
      if (cfg_valid_i && cfg_ready_o) begin
        key_q[cfg_index_i] <= cfg_data_i;
        stale_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= cmd_i;
            din_q <= '{data_word0_i, data_word1_i, data_word2_i, data_word3_i};
            if (stale_q) begin
              state_q <= ST_EXPAND;
              wcnt_q <= '0;
              rcon_q <= 8'h01;
            end else begin
              state_q <= ST_FETCH;
              rnd_q <= cmd_i ? RkW'(ROUND_COUNT - 1) : RkW'(1);
            end
          end
        end
        ST_EXPAND: begin
          win_q <= '{win_q[1], win_q[2], win_q[3], exp_w};
          if (wcnt_q[1:0] == 2'd0 && wcnt_q >= (RkW+2)'(4)) begin
            rcon_q <= {rcon_q[6:0], 1'b0} ^ (rcon_q[7] ? aes_pkg::Reduce : 8'd0);
          end
          wcnt_q <= wcnt_q + 1'b1;
          if (wcnt_q == (RkW+2)'(4*Rounds1-1)) begin
            stale_q <= 1'b0;
            // ST_DONE issues the first round key read
            state_q <= ST_DONE;
            rnd_q <= cmd_q ? RkW'(ROUND_COUNT) : '0;
          end
        end
        ST_DONE: begin
          if (lane_en == 1'b0 && rnd_q != RkW'(Rounds1)) begin
            state_q <= ST_FETCH;
            rnd_q <= cmd_q ? RkW'(ROUND_COUNT - 1) : RkW'(1);
          end
        end
        ST_FETCH, ST_ROUND: begin
          if (state_q == ST_ROUND && ctl.last) begin
            state_q <= ST_IDLE;
            rnd_q <= RkW'(Rounds1);
          end else begin
            state_q <= ST_ROUND;
            if (state_q == ST_ROUND) rnd_q <= cmd_q ? rnd_q - 1'b1 : rnd_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_word0_o = col[0];
  assign result_word1_o = col[1];
  assign result_word2_o = col[2];
  assign result_word3_o = col[3];

endmodule
